>>> design/s3ef_pkg.sv
// Shared constants, types and register codes for the separable 3x3 edge filter.
// Depends on nothing; every other file of the block imports it.
package s3ef_pkg;

	// Geometry limits and field widths.
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int DIM_W      = 11;
	localparam int CMP_W      = DIM_W + 1;
	localparam int PIX_W      = 8;
	localparam int COEF_W     = 8;
	localparam int RS_W       = 18;
	localparam int PROD_W     = COEF_W + RS_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int MAG_W      = ACC_W - 8;
	localparam int POS_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HORIZ_COEF_0 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HORIZ_COEF_1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HORIZ_COEF_2 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_COEF_0  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_COEF_1  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_COEF_2  = 3'd7;

	// Input operation codes.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Step selected for the shared multiply-accumulate unit.
	typedef enum logic [2:0] {
		MAC_NONE,
		MAC_H0,
		MAC_H1,
		MAC_H2,
		MAC_V0,
		MAC_V1,
		MAC_V2
	} mac_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load_in;
		logic     rd_en;
		mac_sel_t mac_sel;
		logic     mem_we;
		logic     out_load;
		logic     finish;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic active;
		logic produce;
		logic out_free;
	} dp_status_t;

endpackage

>>> design/s3ef_pix_if.sv
// Pixel request channel of the edge filter: valid, ready, operation and pixel.
// Depends on s3ef_pkg for the field widths.
interface s3ef_pix_if;
	import s3ef_pkg::*;

	logic             valid;
	logic             ready;
	logic             operation;
	logic [PIX_W-1:0] pixel_value;

	modport source (output valid, output operation, output pixel_value, input ready);
	modport sink (input valid, input operation, input pixel_value, output ready);
endinterface

>>> design/s3ef_edge_if.sv
// Result request channel of the edge filter: valid, ready and the edge fields.
// Depends on s3ef_pkg for the field widths.
interface s3ef_edge_if;
	import s3ef_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] edge_value;
	logic             clipped;
	logic             last;

	modport source (output valid, output edge_value, output clipped, output last, input ready);
	modport sink (input valid, input edge_value, input clipped, input last, output ready);
endinterface

>>> design/separable_3x3_edge_filter_stream_core.sv
// Separable 3x3 edge filter, top level: controller, datapath and the two channels.
// A request that completes a row sum runs six steps of the shared multiplier, H0 to H2 and
// V0 to V2, then loads its result, if any, into the output register; the first two requests
// of an image yield nothing and skip the steps. No new request is taken until the last has
// finished, and a full output register holds the input off. Reset is asynchronous: counters
// and recent pixels clear, registers take their defaults, the line buffer keeps its contents.
module separable_3x3_edge_filter_stream_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [s3ef_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [s3ef_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	s3ef_pix_if.sink                        pixels,
	s3ef_edge_if.source                     edges
);
	import s3ef_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	// Sequencing.
	s3ef_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (pixels.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic, storage and output register.
	s3ef_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.operation   (pixels.operation),
		.pixel_value (pixels.pixel_value),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (edges.ready),
		.out_valid   (edges.valid),
		.edge_value  (edges.edge_value),
		.clipped     (edges.clipped),
		.last        (edges.last)
	);

endmodule

>>> design/s3ef_ctrl.sv
// Sequencing controller of the edge filter: steps the shared multiply-accumulate
// through the row sum and the vertical sum of one pixel. Depends on s3ef_pkg.
module s3ef_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  s3ef_pkg::dp_status_t  status,
	output s3ef_pkg::ctl_cmd_t    cmd
);
	import s3ef_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_H0,
		ST_H1,
		ST_H2,
		ST_V0,
		ST_V1,
		ST_V2,
		ST_RES
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Commands and next state follow the current step.
	always_comb begin
		cmd        = '0;
		cmd.mac_sel = MAC_NONE;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.rd_en   = 1'b1;
				cmd.load_in = accept;
				if (accept) begin
					state_next = status.active ? ST_H0 : ST_RES;
				end
			end
			ST_H0: begin
				cmd.mac_sel = MAC_H0;
				state_next  = ST_H1;
			end
			ST_H1: begin
				cmd.mac_sel = MAC_H1;
				state_next  = ST_H2;
			end
			ST_H2: begin
				cmd.mac_sel = MAC_H2;
				state_next  = ST_V0;
			end
			ST_V0: begin
				cmd.mac_sel = MAC_V0;
				cmd.mem_we  = 1'b1;
				state_next  = ST_V1;
			end
			ST_V1: begin
				cmd.mac_sel = MAC_V1;
				state_next  = ST_V2;
			end
			ST_V2: begin
				cmd.mac_sel = MAC_V2;
				state_next  = ST_RES;
			end
			ST_RES: begin
				// Wait for the output register only when this pixel yields a result.
				if (!status.produce) begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end else if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.finish   = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

>>> design/s3ef_datapath.sv
// Datapath of the edge filter: configuration, raster counters, line buffer,
// shared multiply-accumulate and output register. Depends on s3ef_pkg.
module s3ef_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [s3ef_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [s3ef_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                           operation,
	input  logic [s3ef_pkg::PIX_W-1:0]     pixel_value,
	input  s3ef_pkg::ctl_cmd_t             cmd,
	output s3ef_pkg::dp_status_t           status,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [s3ef_pkg::PIX_W-1:0]     edge_value,
	output logic                           clipped,
	output logic                           last
);
	import s3ef_pkg::*;

	// Configuration registers.
	logic [DIM_W-1:0]         width_cfg_q;
	logic [DIM_W-1:0]         height_cfg_q;
	logic signed [COEF_W-1:0] hcoef_q [3];
	logic signed [COEF_W-1:0] vcoef_q [3];

	// Stream state.
	logic [PIX_W-1:0] pix_q;
	logic [PIX_W-1:0] recent_q [2];
	logic [POS_W-1:0] pos_q;
	logic [COL_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;

	// Line buffer: older row sum in the upper half, newer in the lower half.
	logic [2*RS_W-1:0] line_mem [MAX_WIDTH];
	logic [2*RS_W-1:0] rd_q;
	logic [RS_W-1:0]   rs_q;

	// Multiply-accumulate.
	logic signed [COEF_W-1:0] mac_coef;
	logic signed [RS_W-1:0]   mac_opnd;
	logic                     mac_en;
	logic                     mac_clear;
	logic signed [PROD_W-1:0] mac_prod;
	logic signed [ACC_W-1:0]  mac_term;
	logic signed [ACC_W-1:0]  acc_q;

	// Geometry in use and wide compare operands.
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic [CMP_W-1:0] w12;
	logic [CMP_W-1:0] h12;
	logic [CMP_W-1:0] col12;
	logic [CMP_W-1:0] row12;

	// Result and counter update.
	logic [ACC_W-1:0] abs_acc;
	logic [MAG_W-1:0] mag;
	logic             mag_clip;
	logic             is_last;
	logic             row_wrap;
	logic [COL_W-1:0] col_next;
	logic [DIM_W-1:0] row_next;
	logic             restart;
	logic             out_valid_q;

	// Zero counts as one, anything above the maximum as the maximum.
	always_comb begin
		if (width_cfg_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (width_cfg_q > DIM_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = width_cfg_q;
		end
		if (height_cfg_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (height_cfg_q > DIM_W'(MAX_HEIGHT)) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_cfg_q;
		end
	end

	assign w12   = {1'b0, w_eff};
	assign h12   = {1'b0, h_eff};
	assign col12 = {{(CMP_W-COL_W){1'b0}}, col_q};
	assign row12 = {1'b0, row_q};

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q  <= DIM_W'(MAX_WIDTH);
			height_cfg_q <= DIM_W'(MAX_HEIGHT);
			hcoef_q[0]   <= -8'sd16;
			hcoef_q[1]   <= 8'sd0;
			hcoef_q[2]   <= 8'sd16;
			vcoef_q[0]   <= 8'sd16;
			vcoef_q[1]   <= 8'sd32;
			vcoef_q[2]   <= 8'sd16;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_cfg_q  <= cfg_wr_data;
				REG_IMAGE_HEIGHT: height_cfg_q <= cfg_wr_data;
				REG_HORIZ_COEF_0: hcoef_q[0]   <= cfg_wr_data[COEF_W-1:0];
				REG_HORIZ_COEF_1: hcoef_q[1]   <= cfg_wr_data[COEF_W-1:0];
				REG_HORIZ_COEF_2: hcoef_q[2]   <= cfg_wr_data[COEF_W-1:0];
				REG_VERT_COEF_0:  vcoef_q[0]   <= cfg_wr_data[COEF_W-1:0];
				REG_VERT_COEF_1:  vcoef_q[1]   <= cfg_wr_data[COEF_W-1:0];
				REG_VERT_COEF_2:  vcoef_q[2]   <= cfg_wr_data[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Operand selection for each step; taps beyond the right or bottom edge are dropped.
	always_comb begin
		mac_coef  = '0;
		mac_opnd  = '0;
		mac_en    = 1'b0;
		mac_clear = 1'b0;
		case (cmd.mac_sel)
			MAC_H0: begin
				mac_coef  = hcoef_q[0];
				mac_opnd  = signed'({{(RS_W-PIX_W){1'b0}}, recent_q[0]});
				mac_en    = col12 < w12;
				mac_clear = 1'b1;
			end
			MAC_H1: begin
				mac_coef = hcoef_q[1];
				mac_opnd = signed'({{(RS_W-PIX_W){1'b0}}, recent_q[1]});
				mac_en   = (col12 + CMP_W'(1)) < w12;
			end
			MAC_H2: begin
				mac_coef = hcoef_q[2];
				mac_opnd = signed'({{(RS_W-PIX_W){1'b0}}, pix_q});
				mac_en   = (col12 + CMP_W'(2)) < w12;
			end
			MAC_V0: begin
				mac_coef  = vcoef_q[0];
				mac_opnd  = signed'(rd_q[2*RS_W-1:RS_W]);
				mac_en    = 1'b1;
				mac_clear = 1'b1;
			end
			MAC_V1: begin
				mac_coef = vcoef_q[1];
				mac_opnd = signed'(rd_q[RS_W-1:0]);
				mac_en   = row12 < (h12 + CMP_W'(1));
			end
			MAC_V2: begin
				mac_coef = vcoef_q[2];
				mac_opnd = signed'(rs_q);
				mac_en   = row12 < h12;
			end
			default: begin
			end
		endcase
	end

	assign mac_prod = mac_coef * mac_opnd;
	assign mac_term = mac_en ? {{(ACC_W-PROD_W){mac_prod[PROD_W-1]}}, mac_prod} : '0;

	// Accumulator.
	always_ff @(posedge clk) begin
		if (cmd.mac_sel != MAC_NONE) begin
			acc_q <= mac_clear ? mac_term : acc_q + mac_term;
		end
	end

	// Line buffer: registered read of the current column, then the row sums move up.
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= line_mem[col_q];
		end
		if (cmd.mem_we) begin
			line_mem[col_q] <= {rd_q[RS_W-1:0], acc_q[RS_W-1:0]};
			rs_q            <= acc_q[RS_W-1:0];
		end
	end

	// Incoming pixel; a flush counts as a zero pixel.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pix_q <= (operation == OP_FLUSH) ? '0 : pixel_value;
		end
	end

	// Magnitude, truncation and saturation of the vertical sum.
	assign abs_acc  = acc_q[ACC_W-1] ? unsigned'(-acc_q) : unsigned'(acc_q);
	assign mag      = abs_acc[ACC_W-1:8];
	assign mag_clip = |mag[MAG_W-1:PIX_W];
	assign is_last  = (row12 == h12 + CMP_W'(1)) && (col12 == w12 - CMP_W'(1));

	// A row sum exists from the third pixel on; rows two above it give results.
	assign status.active   = pos_q == POS_W'(2);
	assign status.produce  = status.active && (row_q >= DIM_W'(2)) && (col12 < w12)
		&& (row12 < h12 + CMP_W'(2));
	assign status.out_free = !out_valid_q || out_ready;

	// Raster position after this pixel, and the restart at image end.
	always_comb begin
		row_wrap = status.active && ((col12 + CMP_W'(1)) >= w12);
		col_next = col_q;
		row_next = row_q;
		if (row_wrap) begin
			col_next = '0;
			row_next = row_q + DIM_W'(1);
		end else if (status.active) begin
			col_next = col_q + COL_W'(1);
		end
		restart = {1'b0, row_next} >= (h12 + CMP_W'(2));
	end

	// Stream counters and the two most recent pixels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q[0] <= '0;
			recent_q[1] <= '0;
			pos_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
		end else if (cmd.finish) begin
			if (restart) begin
				recent_q[0] <= '0;
				recent_q[1] <= '0;
				pos_q       <= '0;
				col_q       <= '0;
				row_q       <= '0;
			end else begin
				recent_q[0] <= recent_q[1];
				recent_q[1] <= pix_q;
				pos_q       <= status.active ? pos_q : pos_q + POS_W'(1);
				col_q       <= col_next;
				row_q       <= row_next;
			end
		end
	end

	// Output register: valid holds until the request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			edge_value <= mag_clip ? '1 : mag[PIX_W-1:0];
			clipped    <= mag_clip;
			last       <= is_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> design/s3ef_checker.sv
// Port-level checks of the edge filter, bound to the top level.
// Depends on s3ef_pkg and on the top level's port names.
module s3ef_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [s3ef_pkg::PIX_W-1:0] edge_value,
	input logic                       clipped,
	input logic                       last
);
	import s3ef_pkg::*;

	// An accepted pixel occupies the block for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready in the cycle after an accepted request");

	// A new result appears only while a pixel is being worked on.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the block was idle");

	// Saturation always shows full scale.
	a_clip_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> edge_value == '1)
		else $error("clipped result below full scale");

	// A stalled result holds.
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(edge_value) && $stable(clipped)
			&& $stable(last))
		else $error("stalled result changed");

endmodule

bind separable_3x3_edge_filter_stream_core s3ef_checker u_s3ef_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pixels.valid),
	.in_ready   (pixels.ready),
	.out_valid  (edges.valid),
	.out_ready  (edges.ready),
	.edge_value (edges.edge_value),
	.clipped    (edges.clipped),
	.last       (edges.last)
);
